// ----- hdl/simto_pkg.sv -----
`default_nettype none

package simto_pkg;

    localparam int CharW  = 8;
    localparam int CountW = 16;
    localparam int BurstN = 4;

    typedef logic [CharW-1:0]  t_char;
    typedef logic [CountW-1:0] t_count;
    typedef logic [2:0]        t_nbytes;

    localparam t_count LimitReset = 16'h8000;

    localparam t_char ChPercent = 8'h25;
    localparam t_char ChUnder   = 8'h5F;
    localparam t_char ChCaret   = 8'h5E;
    localparam t_char ChDollar  = 8'h24;
    localparam t_char ChDot     = 8'h2E;
    localparam t_char ChStar    = 8'h2A;
    localparam t_char ChBslash  = 8'h5C;
    localparam t_char ChLbrack  = 8'h5B;
    localparam t_char ChRbrack  = 8'h5D;
    localparam t_char ChBar     = 8'h7C;
    localparam t_char ChPlus    = 8'h2B;
    localparam t_char ChQuery   = 8'h3F;
    localparam t_char ChLbrace  = 8'h7B;
    localparam t_char ChRbrace  = 8'h7D;
    localparam t_char ChLparen  = 8'h28;
    localparam t_char ChRparen  = 8'h29;

    // Bytes produced by one pattern character, handed from decode to serialiser
    typedef struct packed {
        logic                    load;
        t_nbytes                 nbytes;
        t_char [BurstN-1:0]      bytes;
        logic                    done;
    } t_burst;

    // SIMILAR TO operators that are literal in POSIX
    function automatic logic is_operator(input t_char ch);
        return ch inside {ChBar, ChPlus, ChQuery, ChLbrace, ChRbrace, ChLparen, ChRparen};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/simto_in_if.sv -----
`default_nettype none

interface simto_in_if;
    logic             valid;
    logic             ready;
    simto_pkg::t_char pattern_char;
    logic             is_first;
    logic             is_last;

    modport source (output valid, output pattern_char, output is_first, output is_last,
                    input ready);
    modport sink (input valid, input pattern_char, input is_first, input is_last,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/simto_out_if.sv -----
`default_nettype none

interface simto_out_if;
    logic             valid;
    logic             ready;
    simto_pkg::t_char regex_byte;
    logic             run_last;
    logic             pattern_done;

    modport source (output valid, output regex_byte, output run_last, output pattern_done,
                    input ready);
    modport sink (input valid, input regex_byte, input run_last, input pattern_done,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/simto_decode.sv -----
`default_nettype none

module simto_decode (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    simto_in_if.sink               i_pat,
    input  wire logic              i_cfg_wr_en,
    input  wire simto_pkg::t_count i_cfg_wr_data,
    input  wire logic              i_burst_ready,
    output simto_pkg::t_burst      o_burst
);
    import simto_pkg::*;

    logic    r_in_valid;
    t_char   r_in_char;
    logic    r_in_first;
    logic    r_in_last;
    logic    r_escape;
    t_count  r_count;
    t_count  r_output_limit;

    logic    take;
    logic    esc;
    t_count  cnt;
    logic    in_limit;
    logic [1:0] body_n;
    t_char   body0;
    t_char   body1;
    logic    esc_body;
    logic [CountW:0] sum;
    logic    n_escape;
    t_count  n_count;
    t_burst  burst;
    int      rel;

    assign take        = r_in_valid && i_burst_ready;
    assign i_pat.ready = !r_in_valid || take;

    always_comb begin
        esc      = r_in_first ? 1'b0 : r_escape;
        cnt      = r_in_first ? t_count'(1) : r_count;
        in_limit = cnt < r_output_limit;
        body_n   = 2'd0;
        body0    = r_in_char;
        body1    = r_in_char;
        esc_body = esc;
        if (in_limit) begin
            esc_body = 1'b0;
            if (esc && (r_in_char == ChPercent || r_in_char == ChUnder
                        || is_operator(r_in_char))) begin
                body_n = 2'd1;
            end else if (esc && (r_in_char inside {ChBslash, ChStar, ChLbrack, ChRbrack})) begin
                body_n = 2'd2;
                body0  = ChBslash;
            end else if (r_in_char == ChPercent) begin
                body_n = 2'd2;
                body0  = ChDot;
                body1  = ChStar;
            end else if (r_in_char == ChUnder) begin
                body_n = 2'd1;
                body0  = ChDot;
            end else if (r_in_char == ChBslash) begin
                esc_body = 1'b1;
            end else if (r_in_char == ChDot || is_operator(r_in_char)) begin
                body_n = 2'd2;
                body0  = ChBslash;
            end else begin
                body_n = 2'd1;
            end
        end

        sum      = {1'b0, cnt} + (CountW+1)'(body_n);
        n_count  = sum[CountW] ? '1 : sum[CountW-1:0];
        n_escape = r_in_last ? 1'b0 : esc_body;

        // caret, then body bytes, then dollar
        burst.load   = take;
        burst.nbytes = t_nbytes'(r_in_first) + t_nbytes'(body_n) + t_nbytes'(r_in_last);
        burst.done   = r_in_last;
        for (int s = 0; s < BurstN; s++) begin
            rel = s - int'(r_in_first);
            if (r_in_first && s == 0) begin
                burst.bytes[s] = ChCaret;
            end else if (rel < int'(body_n)) begin
                burst.bytes[s] = (rel == 0) ? body0 : body1;
            end else begin
                burst.bytes[s] = ChDollar;
            end
        end
    end

    assign o_burst = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_escape       <= 1'b0;
            r_count        <= '0;
            r_output_limit <= LimitReset;
        end else begin
            if (i_pat.valid && i_pat.ready) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            if (take) begin
                r_escape <= n_escape;
                r_count  <= n_count;
            end
            if (i_cfg_wr_en) begin
                r_output_limit <= i_cfg_wr_data;
            end
        end
        if (i_pat.valid && i_pat.ready) begin
            r_in_char  <= i_pat.pattern_char;
            r_in_first <= i_pat.is_first;
            r_in_last  <= i_pat.is_last;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/simto_serial.sv -----
`default_nettype none

module simto_serial (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire simto_pkg::t_burst i_burst,
    output logic                  o_burst_ready,
    simto_out_if.source           o_rx
);
    import simto_pkg::*;

    t_char   r_bytes [BurstN];
    t_nbytes r_nbytes;
    logic    r_done;
    logic    pop;

    assign o_rx.valid        = r_nbytes != '0;
    assign o_rx.regex_byte   = r_bytes[0];
    assign o_rx.run_last     = r_nbytes == t_nbytes'(1);
    assign o_rx.pattern_done = r_done && (r_nbytes == t_nbytes'(1));

    assign pop           = o_rx.valid && o_rx.ready;
    assign o_burst_ready = (r_nbytes == '0) || (r_nbytes == t_nbytes'(1) && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nbytes <= '0;
        end else if (i_burst.load) begin
            r_nbytes <= i_burst.nbytes;
        end else if (pop) begin
            r_nbytes <= r_nbytes - t_nbytes'(1);
        end
        if (i_burst.load) begin
            r_done <= i_burst.done;
            for (int i = 0; i < BurstN; i++) begin
                r_bytes[i] <= i_burst.bytes[i];
            end
        end else if (pop) begin
            for (int i = 0; i < BurstN-1; i++) begin
                r_bytes[i] <= r_bytes[i+1];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/similar_to_pattern_to_regex_unit.sv -----
// Channel    Dir  Transaction
// i_pat      in   one pattern character with first/last flags
// o_rx       out  one regex byte with run_last and pattern_done
// i_cfg_*    in   output_limit write, no read-back
//
// Each character gives 0 to 4 regex bytes (caret, up to two body bytes,
// dollar); the output channel moves one byte per cycle while o_rx.ready is
// high, and the next character's bytes can load as the last byte of the one
// before is taken. The first byte passes the input register and then the
// output buffer before it is valid. Synchronous reset clears the escape flag
// and byte count and sets output_limit to 32768. An input register and a
// four-byte output buffer decouple the two sides under stalls.
`default_nettype none

module similar_to_pattern_to_regex_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    simto_in_if.sink               i_pat,
    simto_out_if.source            o_rx,
    input  wire logic              i_cfg_wr_en,
    input  wire simto_pkg::t_count i_cfg_wr_data
);
    import simto_pkg::*;

    t_burst burst;
    logic   burst_ready;

    simto_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pat         (i_pat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_burst_ready (burst_ready),
        .o_burst       (burst)
    );

    simto_serial u_serial (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_burst       (burst),
        .o_burst_ready (burst_ready),
        .o_rx          (o_rx)
    );

endmodule

`default_nettype wire

// ----- tb/simto_regex_checker.sv -----
`default_nettype none

module simto_regex_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_pat_valid,
    input  wire logic              i_pat_ready,
    input  wire simto_pkg::t_char  i_pat_char,
    input  wire logic              i_pat_first,
    input  wire logic              i_pat_last,
    input  wire logic              i_rx_valid,
    input  wire logic              i_rx_ready,
    input  wire simto_pkg::t_char  i_rx_byte,
    input  wire logic              i_rx_run_last,
    input  wire logic              i_rx_done,
    input  wire logic              i_cfg_wr_en,
    input  wire simto_pkg::t_count i_cfg_wr_data,
    output int                     o_fail_count,
    output int                     o_pending
);
    import simto_pkg::*;

    typedef struct packed {
        t_char ch;
        logic  run_last;
        logic  done;
    } t_regex_byte;

    t_regex_byte expected_bytes[$];
    t_count      limit_q;
    t_count      byte_count;
    logic        esc_held;

    function automatic logic is_similar_op(input t_char c);
        case (c)
            ChBar, ChPlus, ChQuery, ChLbrace, ChRbrace, ChLparen, ChRparen: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // saturating count of caret and body bytes
    function automatic t_count bump(input t_count c, input int amount);
        int sum;
        sum = int'(c) + amount;
        return (sum > 65535) ? 16'hFFFF : t_count'(sum);
    endfunction

    task automatic emit(input t_char b, input logic done);
        expected_bytes.push_back('{b, 1'b0, done});
    endtask

    task automatic translate_char(input t_char ch, input logic first, input logic last);
        int          base;
        logic        handled;
        t_regex_byte tail;
        base    = expected_bytes.size();
        handled = 1'b0;
        if (first) begin
            esc_held   = 1'b0;
            byte_count = '0;
            emit(ChCaret, 1'b0);
            byte_count = bump(byte_count, 1);
        end
        if (byte_count < limit_q) begin
            if (esc_held) begin
                esc_held = 1'b0;
                if (ch == ChPercent || ch == ChUnder || is_similar_op(ch)) begin
                    emit(ch, 1'b0);
                    byte_count = bump(byte_count, 1);
                    handled    = 1'b1;
                end else if (ch == ChBslash || ch == ChStar || ch == ChLbrack
                             || ch == ChRbrack) begin
                    emit(ChBslash, 1'b0);
                    emit(ch, 1'b0);
                    byte_count = bump(byte_count, 2);
                    handled    = 1'b1;
                end
            end
            // an escape that does not apply is dropped and the char taken as is
            if (!handled) begin
                if (ch == ChPercent) begin
                    emit(ChDot, 1'b0);
                    emit(ChStar, 1'b0);
                    byte_count = bump(byte_count, 2);
                end else if (ch == ChUnder) begin
                    emit(ChDot, 1'b0);
                    byte_count = bump(byte_count, 1);
                end else if (ch == ChBslash) begin
                    esc_held = 1'b1;
                end else if (ch == ChDot || is_similar_op(ch)) begin
                    emit(ChBslash, 1'b0);
                    emit(ch, 1'b0);
                    byte_count = bump(byte_count, 2);
                end else begin
                    emit(ch, 1'b0);
                    byte_count = bump(byte_count, 1);
                end
            end
        end
        if (last) begin
            esc_held = 1'b0;
            emit(ChDollar, 1'b1);
        end
        if (expected_bytes.size() > base) begin
            tail          = expected_bytes.pop_back();
            tail.run_last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_regex_byte want;
        if (!i_rst_n) begin
            limit_q      = LimitReset;
            byte_count   = '0;
            esc_held     = 1'b0;
            o_fail_count = 0;
            expected_bytes.delete();
        end else begin
            if (i_pat_valid && i_pat_ready)
                translate_char(i_pat_char, i_pat_first, i_pat_last);
            if (i_rx_valid && i_rx_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("regex byte with nothing expected", i_rx_byte, 0);
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_rx_byte !== want.ch)
                        report_mismatch("regex_byte", i_rx_byte, want.ch);
                    if (i_rx_run_last !== want.run_last)
                        report_mismatch("run_last", i_rx_run_last, want.run_last);
                    if (i_rx_done !== want.done)
                        report_mismatch("pattern_done", i_rx_done, want.done);
                end
            end
            if (i_cfg_wr_en)
                limit_q = i_cfg_wr_data;
        end
        o_pending = expected_bytes.size();
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
    import simto_pkg::*;

    localparam int     StallLimit = 2000;
    localparam t_char  ChLowA     = 8'h61;
    localparam t_char  ChLowZ     = 8'h7A;

    logic   i_clk;
    logic   i_rst_n;
    logic   cfg_wr_en;
    t_count cfg_wr_data;
    int     fail_count;
    int     pending;
    int     bytes_seen;
    int     quiet_cycles;
    bit     burst_mode;
    bit     pressure_on;

    simto_in_if  pat_if ();
    simto_out_if rx_if ();

    similar_to_pattern_to_regex_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pat         (pat_if),
        .o_rx          (rx_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    simto_regex_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pat_valid   (pat_if.valid),
        .i_pat_ready   (pat_if.ready),
        .i_pat_char    (pat_if.pattern_char),
        .i_pat_first   (pat_if.is_first),
        .i_pat_last    (pat_if.is_last),
        .i_rx_valid    (rx_if.valid),
        .i_rx_ready    (rx_if.ready),
        .i_rx_byte     (rx_if.regex_byte),
        .i_rx_run_last (rx_if.run_last),
        .i_rx_done     (rx_if.pattern_done),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one pattern character; returns at the falling edge after its transaction
    task automatic send_char(input t_char ch, input logic first, input logic last);
        int gap;
        gap = (burst_mode || pressure_on) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            pat_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pat_if.valid        <= 1'b1;
        pat_if.pattern_char <= ch;
        pat_if.is_first     <= first;
        pat_if.is_last      <= last;
        do @(posedge i_clk); while (!(pat_if.valid && pat_if.ready));
        @(negedge i_clk);
    endtask

    // wait for the block to drain, with margin for items that emit nothing
    task automatic settle();
        pat_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_limit(input t_count value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic t_char pick_char();
        if ($urandom_range(0, 1) == 0)
            return t_char'($urandom_range(1, 255));
        case ($urandom_range(0, 15))
            0:  return ChPercent;
            1:  return ChUnder;
            2:  return ChDot;
            3:  return ChStar;
            4:  return ChLbrack;
            5:  return ChRbrack;
            6:  return ChBar;
            7:  return ChPlus;
            8:  return ChQuery;
            9:  return ChLbrace;
            10: return ChRbrace;
            11: return ChLparen;
            12: return ChRparen;
            13: return ChCaret;
            14: return ChDollar;
            default: return ChBslash;
        endcase
    endfunction

    // mostly well-formed patterns; now and then a missing or stray flag
    task automatic send_pattern(input int len);
        logic first;
        logic last;
        burst_mode = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            first = (i == 0);
            last  = (i == len - 1);
            if ($urandom_range(0, 9) == 0) first = ~first;
            if ($urandom_range(0, 9) == 0) last = ~last;
            send_char(pick_char(), first, last);
        end
    endtask

    initial begin : stimulus
        t_count lim;
        int     sent;
        int     len;
        i_rst_n             = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        pat_if.valid        = 1'b0;
        pat_if.pattern_char = '0;
        pat_if.is_first     = 1'b0;
        pat_if.is_last      = 1'b0;
        burst_mode          = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, at the reset limit
        send_char(ChPercent, 1'b1, 1'b1);
        send_char(8'h01, 1'b1, 1'b0);
        send_char(ChUnder, 1'b0, 1'b0);
        send_char(ChDot, 1'b0, 1'b0);
        send_char(ChBar, 1'b0, 1'b0);
        send_char(ChPlus, 1'b0, 1'b0);
        send_char(ChQuery, 1'b0, 1'b0);
        send_char(ChLbrace, 1'b0, 1'b0);
        send_char(ChRbrace, 1'b0, 1'b0);
        send_char(ChLparen, 1'b0, 1'b0);
        send_char(ChRparen, 1'b0, 1'b0);
        send_char(8'hFF, 1'b0, 1'b0);
        send_char(ChBslash, 1'b0, 1'b0);
        send_char(ChPercent, 1'b0, 1'b0);
        send_char(ChBslash, 1'b0, 1'b0);
        send_char(ChBslash, 1'b0, 1'b0);
        send_char(ChBslash, 1'b0, 1'b0);
        send_char(ChLowA, 1'b0, 1'b0);
        send_char(ChBslash, 1'b0, 1'b0);
        send_char(ChDot, 1'b0, 1'b1);
        // no first flag: carries on from the previous count
        send_char(ChLowZ, 1'b0, 1'b0);
        send_char(ChBslash, 1'b0, 1'b1);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       lim = 16'd2;
                1:       lim = 16'hFFFF;
                2:       lim = t_count'($urandom_range(3, 6));
                3:       lim = t_count'($urandom_range(7, 20));
                4:       lim = 16'd2;
                default: lim = t_count'($urandom_range(2, 65535));
            endcase
            write_limit(lim);
            sent = 0;
            while (sent < 32) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24)
                                                  : $urandom_range(1, 8);
                send_pattern(len);
                sent += len;
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : regex_sink
        int gap;
        bytes_seen  = 0;
        pressure_on = 1'b0;
        rx_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            // long hold-off so the block backs up and stalls its input
            if (bytes_seen == 120 || bytes_seen == 400) begin
                rx_if.ready <= 1'b0;
                pressure_on = 1'b1;
                repeat (90) @(negedge i_clk);
                pressure_on = 1'b0;
            end
            gap = burst_mode ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                rx_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rx_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(rx_if.valid && rx_if.ready));
            bytes_seen++;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pat_if.valid && pat_if.ready) || (rx_if.valid && rx_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
